>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL of the debounce block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BDC_ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: invariant violated");

// Property whose consequent must hold in the cycle after the antecedent.
`define BDC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check violated");

`endif

>>> sv/bdc_pkg.sv
// ---------------------------------------------------------------------------
// bdc_pkg
// Types and constants of the button debounce and click detector.
// ---------------------------------------------------------------------------
package bdc_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned INTEG_W = 8;
  localparam int unsigned CLICK_W = 8;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [INTEG_W-1:0] TOP_MIN   = 8'd2;
  localparam logic [INTEG_W-1:0] INTEG_MIN = 8'd1;
  localparam logic [CLICK_W-1:0] CLICK_MAX = 8'd255;

  localparam logic [INTEG_W-1:0] RST_DEBOUNCE_TOP = 8'd16;
  localparam logic [TICK_W-1:0]  RST_CLICK_WINDOW = 32'd16000000;
  localparam logic [TICK_W-1:0]  RST_LONG_PRESS   = 32'd80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TOP = 2'd0,
    REG_CLICK_WINDOW = 2'd1,
    REG_LONG_PRESS   = 2'd2
  } bdc_reg_t;

  typedef struct packed {
    logic [INTEG_W-1:0] debounce_top;
    logic [TICK_W-1:0]  click_window_ticks;
    logic [TICK_W-1:0]  long_press_ticks;
  } bdc_cfg_t;

  typedef struct packed {
    logic busy_res;
    logic key_down;
    logic single_click;
    logic short_press;
    logic long_press;
  } bdc_res_t;

endpackage

>>> sv/bdc_cfg.sv
// ---------------------------------------------------------------------------
// bdc_cfg
// Configuration register file, written through the cfg channel.
// ---------------------------------------------------------------------------
module bdc_cfg
  import bdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  output bdc_cfg_t             cfg
);

  bdc_cfg_t cfg_r;
  bdc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg         = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (bdc_reg_t'(cfg_index))
        REG_DEBOUNCE_TOP: cfg_nxt.debounce_top       = cfg_data[INTEG_W-1:0];
        REG_CLICK_WINDOW: cfg_nxt.click_window_ticks = cfg_data;
        REG_LONG_PRESS:   cfg_nxt.long_press_ticks   = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_top       <= RST_DEBOUNCE_TOP;
      cfg_r.click_window_ticks <= RST_CLICK_WINDOW;
      cfg_r.long_press_ticks   <= RST_LONG_PRESS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/bdc_core.sv
// ---------------------------------------------------------------------------
// bdc_core
// Debounce state and the per-poll update that yields one result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdc_core
  import bdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              pin_level,
  input  logic [TICK_W-1:0] now_ticks,
  input  bdc_cfg_t          cfg,
  output bdc_res_t          res
);

  logic [INTEG_W-1:0] integ_r, integ_nxt;
  logic               press_flag_r, press_flag_nxt;
  logic [TICK_W-1:0]  press_stamp_r, press_stamp_nxt;
  logic [TICK_W-1:0]  release_stamp_r, release_stamp_nxt;
  logic [CLICK_W-1:0] click_r, click_nxt;

  logic [INTEG_W-1:0] top;
  logic [INTEG_W-1:0] integ_up, integ_dn;
  logic [TICK_W-1:0]  since_release, since_press;
  logic               click_expired, long_held;
  logic               press_ev, release_ev;

  assign top      = (cfg.debounce_top < TOP_MIN) ? TOP_MIN : cfg.debounce_top;
  assign integ_up = integ_r + 8'd1;
  assign integ_dn = integ_r - 8'd1;

  // Wrapped differences; both references are the values before this poll.
  assign since_release = now_ticks - release_stamp_r;
  assign since_press   = now_ticks - press_stamp_r;
  assign click_expired = since_release > cfg.click_window_ticks;
  assign long_held     = since_press > cfg.long_press_ticks;

  always_comb begin
    integ_nxt         = integ_r;
    press_flag_nxt    = press_flag_r;
    press_stamp_nxt   = press_stamp_r;
    release_stamp_nxt = release_stamp_r;
    click_nxt         = click_r;
    press_ev          = 1'b0;
    release_ev        = 1'b0;
    res               = '0;

    if (!pin_level) begin
      if (integ_r < top) begin
        integ_nxt = integ_up;
        if (integ_up == top) begin
          press_ev        = 1'b1;
          press_flag_nxt  = 1'b1;
          press_stamp_nxt = now_ticks;
          if (!click_expired) begin
            click_nxt = (click_r == CLICK_MAX) ? click_r : click_r + 8'd1;
          end else begin
            click_nxt = 8'd1;
          end
        end
      end
    end else begin
      if (integ_r > INTEG_MIN) begin
        integ_nxt = integ_dn;
        if (integ_dn == INTEG_MIN && press_flag_r) begin
          release_ev        = 1'b1;
          release_stamp_nxt = now_ticks;
        end
      end else if (integ_r == '0) begin
        integ_nxt = INTEG_MIN;
      end
    end

    // A release only happens with a press pending, so the click window
    // check below never sees the stamp that was just written.
    if (release_ev) begin
      press_flag_nxt  = 1'b0;
      res.long_press  = long_held;
      res.short_press = !long_held;
    end else if (!press_flag_nxt && click_expired) begin
      res.single_click = (click_r == 8'd1);
      click_nxt        = '0;
    end

    res.key_down = press_flag_nxt;
    res.busy_res = (integ_nxt != INTEG_MIN && integ_nxt != top) || press_flag_nxt ||
                   (click_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r         <= INTEG_MIN;
      press_flag_r    <= 1'b0;
      press_stamp_r   <= '0;
      release_stamp_r <= '0;
      click_r         <= '0;
    end else if (adv) begin
      integ_r         <= integ_nxt;
      press_flag_r    <= press_flag_nxt;
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
      click_r         <= click_nxt;
    end
  end

  `BDC_ASSERT_ALWAYS(a_integ_nonzero, clk, rst_n, integ_r != '0)
  `BDC_ASSERT_ALWAYS(a_press_release_excl, clk, rst_n, !(adv && press_ev && release_ev))
  `BDC_ASSERT_NEXT(a_done_clears_press, clk, rst_n,
                   adv && (res.long_press || res.short_press), !press_flag_r)
  `BDC_ASSERT_NEXT(a_single_clears_count, clk, rst_n, adv && res.single_click, click_r == '0)

endmodule

>>> sv/button_debounce_click_detector_unit.sv
// ---------------------------------------------------------------------------
// button_debounce_click_detector_unit
// Debounces an active-low button and reports long, short and single clicks.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one poll per beat: the raw pin level and a
//   free-running 32-bit timestamp. Every poll yields exactly one out_ beat
//   with the press flags, the debounced key state and a busy flag.
//   The cfg channel writes debounce_top, click_window_ticks and
//   long_press_ticks by index; write it only while no poll is in flight.
//   A poll is held in the input register while the update logic runs, and
//   its result moves to the output register when that register is free.
//   One poll is taken per cycle, back to back, while out_tready stays high;
//   the state update is a pair of 32-bit subtract-and-compare paths.
//   When out_tready is low the result holds in the output register and the
//   input register still takes one more beat; after that in_tready drops
//   until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers, sets the integrator
//   to 1, clears flags, stamps and click count and loads register defaults.
// ---------------------------------------------------------------------------
module button_debounce_click_detector_unit
  import bdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] pin_level, [32:1] now_ticks
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] long_press, [1] short_press,
                                             // [2] single_click, [3] key_down,
                                             // [4] busy_res
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TICK_W-1:0]      cfg_data
);

  logic              in_v_r;
  logic              pin_r;
  logic [TICK_W-1:0] now_r;
  logic              out_v_r;
  bdc_res_t          out_r;
  bdc_res_t          res;
  bdc_cfg_t          cfg;
  logic              adv;

  // The held poll moves to the output register when that register is free.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  bdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .pin_level (pin_r),
    .now_ticks (now_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pin_r <= in_tdata[0];
      now_r <= in_tdata[TICK_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_r.busy_res, out_r.key_down, out_r.single_click,
                       out_r.short_press, out_r.long_press};

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the button debounce and click detector.
// A queue of polls feeds a stream driver; every accepted poll runs through a
// software copy of the debounce state, and the monitor compares each result
// beat field by field against the oldest prediction. Stimulus starts with
// hand-placed polls around the timing boundaries, then runs press/release
// sequences with random bounce and timing under several register settings,
// including the extremes of every register.
// ---------------------------------------------------------------------------
module tb_top;
  import bdc_pkg::*;

  localparam int IDLE_PCT    = 21;
  localparam int LATENCY     = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = REG_DEBOUNCE_TOP;
  logic [TICK_W-1:0]      cfg_data   = '0;

  button_debounce_click_detector_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies and debounce state of the predictor.
  logic [INTEG_W-1:0] top_reg      = RST_DEBOUNCE_TOP;
  logic [TICK_W-1:0]  window_reg   = RST_CLICK_WINDOW;
  logic [TICK_W-1:0]  long_reg     = RST_LONG_PRESS;
  logic [INTEG_W-1:0] integ_lvl    = INTEG_MIN;
  logic               key_held     = 1'b0;
  logic [TICK_W-1:0]  press_time   = '0;
  logic [TICK_W-1:0]  release_time = '0;
  logic [CLICK_W-1:0] click_cnt    = '0;

  logic [IN_TDATA_W-1:0] pending_polls[$];
  bdc_res_t              expected_res[$];
  logic [TICK_W-1:0]     tick_now = '0;
  bit                    steady   = 1'b0;

  int err_cnt      = 0;
  int polls_sent   = 0;
  int results_seen = 0;
  int long_cnt     = 0;
  int short_cnt    = 0;
  int single_cnt   = 0;
  int settings_cnt = 0;
  int quiet_cycles = 0;

  function automatic logic [INTEG_W-1:0] eff_top();
    return (top_reg < TOP_MIN) ? TOP_MIN : top_reg;
  endfunction

  // Wrapped elapsed time strictly beyond the limit.
  function automatic logic expired(input logic [TICK_W-1:0] now_t,
                                   input logic [TICK_W-1:0] ref_t,
                                   input logic [TICK_W-1:0] limit);
    logic [TICK_W-1:0] diff;
    diff = now_t - ref_t;
    return diff > limit;
  endfunction

  function automatic bdc_res_t debounce_predict(input logic pin,
                                                input logic [TICK_W-1:0] now_t);
    logic [INTEG_W-1:0] top;
    logic               released;
    bdc_res_t           res;
    top      = eff_top();
    released = 1'b0;
    res      = '0;
    if (!pin) begin
      // An integrator left above a lowered top holds and cannot press again.
      if (integ_lvl < top) begin
        integ_lvl = integ_lvl + 1'b1;
        if (integ_lvl == top) begin
          key_held   = 1'b1;
          press_time = now_t;
          if (!expired(now_t, release_time, window_reg)) begin
            if (click_cnt != CLICK_MAX) click_cnt = click_cnt + 1'b1;
          end else begin
            click_cnt = 8'd1;
          end
        end
      end
    end else if (integ_lvl > INTEG_MIN) begin
      integ_lvl = integ_lvl - 1'b1;
      if (integ_lvl == INTEG_MIN && key_held) begin
        released     = 1'b1;
        release_time = now_t;
      end
    end else if (integ_lvl == '0) begin
      integ_lvl = INTEG_MIN;
    end
    if (key_held && released) begin
      key_held = 1'b0;
      if (expired(now_t, press_time, long_reg)) res.long_press = 1'b1;
      else res.short_press = 1'b1;
    end else if (!key_held && expired(now_t, release_time, window_reg)) begin
      if (click_cnt == 1) res.single_click = 1'b1;
      click_cnt = '0;
    end
    res.key_down = key_held;
    res.busy_res = (integ_lvl != INTEG_MIN && integ_lvl != top) || key_held ||
                   click_cnt != 0;
    return res;
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic want, input logic got);
    if (want !== got)
      note_error($sformatf("result %0d %s: expected %b, got %b",
                           results_seen, name, want, got));
  endtask

  task automatic check_result(input bdc_res_t got);
    bdc_res_t want;
    if (expected_res.size() == 0) begin
      note_error($sformatf("result %0d arrived with nothing expected (%b)",
                           results_seen, got));
    end else begin
      want = expected_res.pop_front();
      compare_field("long_press", want.long_press, got.long_press);
      compare_field("short_press", want.short_press, got.short_press);
      compare_field("single_click", want.single_click, got.single_click);
      compare_field("key_down", want.key_down, got.key_down);
      compare_field("busy_res", want.busy_res, got.busy_res);
      long_cnt   += want.long_press;
      short_cnt  += want.short_press;
      single_cnt += want.single_click;
    end
    results_seen++;
  endtask

  // Poll driver: predicts on every accepted beat, then offers the next poll.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_res.push_back(debounce_predict(in_tdata[0], in_tdata[TICK_W:1]));
        polls_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_polls.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_polls.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure, off while steady is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(bdc_res_t'(out_tdata[4:0]));
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: ends the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input bdc_reg_t idx, input logic [TICK_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE_TOP: top_reg    = val[INTEG_W-1:0];
      REG_CLICK_WINDOW: window_reg = val;
      REG_LONG_PRESS:   long_reg   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [INTEG_W-1:0] top, input logic [TICK_W-1:0] window,
                          input logic [TICK_W-1:0] hold);
    write_reg(REG_DEBOUNCE_TOP, {{(TICK_W-INTEG_W){1'b0}}, top});
    write_reg(REG_CLICK_WINDOW, window);
    write_reg(REG_LONG_PRESS, hold);
    settings_cnt++;
  endtask

  // Sender holds off until every result is back, then lets the pipe settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_polls.size() != 0 || in_tvalid || expected_res.size() != 0);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic add_poll(input logic pin, input logic [TICK_W-1:0] t);
    tick_now = t;
    pending_polls.push_back({{(IN_TDATA_W-TICK_W-1){1'b0}}, t, pin});
  endtask

  // Time jumps scattered around a register value, to land near its boundary.
  function automatic logic [TICK_W-1:0] pick_span(input logic [TICK_W-1:0] x);
    case ($urandom_range(0, 5))
      0:       return x - $urandom_range(0, 6);
      1:       return x + $urandom_range(0, 6);
      2:       return $urandom();
      3:       return $urandom_range(0, x);
      4:       return $urandom_range(0, 3);
      default: return x;
    endcase
  endfunction

  // Press/release sequences with bounce; about one in ten is cut short.
  task automatic add_taps(input int n);
    int cnt;
    int top;
    int len;
    int jump_at;
    cnt = 0;
    while (cnt < n) begin
      top = eff_top();
      repeat ($urandom_range(0, 2)) begin
        add_poll(1'($urandom_range(0, 1)), tick_now + $urandom_range(0, 3));
        cnt++;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, top) : top + $urandom_range(0, 3);
      jump_at = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++)
        add_poll($urandom_range(0, 9) == 0,
                 tick_now + ((i == jump_at) ? pick_span(long_reg) : $urandom_range(0, 2)));
      cnt += len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, top) : top + $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        add_poll($urandom_range(0, 9) != 0, tick_now + $urandom_range(0, 2));
      add_poll(1'b1, tick_now + pick_span(window_reg));
      cnt += len + 1;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings; these alternating polls stay below the reset top, so no press completes.
    add_poll(1'b0, 32'h0000_0000);
    add_poll(1'b1, 32'hFFFF_FFFF);
    add_poll(1'b0, 32'h8000_0000);
    add_poll(1'b1, 32'h0000_0001);
    drain();

    // A top of zero acts as two, so a single low poll completes a press and a single high poll a release.
    set_regs(8'd0, 32'd100, 32'd50);
    add_poll(1'b0, 32'd10);
    add_poll(1'b0, 32'd20);
    add_poll(1'b1, 32'd30);
    add_poll(1'b1, 32'd200);
    add_poll(1'b0, 32'd250);
    add_poll(1'b1, 32'd400);
    add_poll(1'b0, 32'd450);
    add_poll(1'b1, 32'd460);
    add_poll(1'b0, 32'd470);
    add_poll(1'b1, 32'd480);
    add_poll(1'b1, 32'd1000);
    add_poll(1'b0, 32'hFFFF_FFF0);
    add_poll(1'b1, 32'h0000_0010);
    add_poll(1'b0, 32'h0000_0020);
    add_poll(1'b1, 32'h0000_0052);
    add_poll(1'b0, 32'h0000_00B6);
    add_poll(1'b1, 32'h0000_00E9);
    add_poll(1'b1, 32'h0000_014E);
    drain();

    // Stretch without any idling on either side, split by a full pause.
    steady = 1'b1;
    set_regs(8'($urandom_range(3, 6)), 32'd1000, 32'd3000);
    add_taps(90);
    drain();
    add_taps(90);
    drain();
    steady = 1'b0;

    // Full-scale top, then lowered while the button is still held down.
    set_regs(8'd255, 32'd400, 32'd2000);
    for (int i = 0; i < 256; i++)
      add_poll(1'b0, tick_now + ((i == 100) ? pick_span(long_reg) : $urandom_range(0, 2)));
    drain();
    write_reg(REG_DEBOUNCE_TOP, 32'd2);
    repeat (6) add_poll(1'b0, tick_now + $urandom_range(0, 2));
    for (int i = 0; i < 255; i++)
      add_poll(1'b1, tick_now + $urandom_range(0, 2));
    add_taps(30);
    drain();

    // Click window that never closes drives the click count into saturation.
    set_regs(8'd1, 32'hFFFF_FFFF, 32'd0);
    repeat (265) begin
      add_poll(1'b0, tick_now + $urandom_range(0, 1));
      add_poll(1'b1, tick_now + $urandom_range(0, 1));
    end
    drain();

    set_regs(8'd2, 32'd0, 32'hFFFF_FFFF);
    add_taps(150);
    drain();

    set_regs(8'($urandom_range(2, 8)), $urandom(), $urandom());
    add_taps(200);
    drain();

    set_regs(8'd4, 32'd5000, 32'd0);
    add_taps(150);
    drain();

    set_regs(RST_DEBOUNCE_TOP, RST_CLICK_WINDOW, RST_LONG_PRESS);
    add_taps(200);
    drain();

    $display("Drove %0d polls under %0d register settings; checked %0d result beats.",
             polls_sent, settings_cnt, results_seen);
    $display("Predicted events: %0d long presses, %0d short presses, %0d single clicks.",
             long_cnt, short_cnt, single_cnt);
    if (err_cnt == 0 && expected_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d", err_cnt);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/bdc_pkg.sv
sv/bdc_cfg.sv
sv/bdc_core.sv
sv/button_debounce_click_detector_unit.sv
tb/sv/tb_top.sv
